// File: hdl/qtpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtpe_pkg
// Shared types, character codes and helpers for the quoted-printable encoder.
// ----------------------------------------------------------------------------
package qtpe_pkg;

    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_EQ  = 8'h3D;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_LT  = 8'h3C;
    localparam logic [7:0] CHAR_GT  = 8'h3E;
    localparam logic [7:0] CHAR_TLD = 8'h7E;
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_A   = 8'h41;

    // characters one input item may cause at most
    localparam logic [3:0] MAX_CHARS = 4'd9;

    localparam int CMD_FIFO_DEPTH = 4;
    localparam int CMD_PTR_W      = 2;

    // one encoding command: optional soft break, then one token
    typedef struct packed {
        logic       brk;       // "=" CR LF before the token
        logic       crlf;      // token is a hard break
        logic       esc;       // token is "=" plus two hex digits
        logic [7:0] data;      // raw byte of the token
        logic [2:0] len;       // characters to emit, 1 to 6
        logic       last;      // last command of its item
        logic       done;      // last command of the message
    } cmd_t;

    function automatic logic is_literal(input logic [7:0] b);
        is_literal = (b == CHAR_TAB) ||
                     ((b >= CHAR_SP) && (b <= CHAR_LT)) ||
                     ((b >= CHAR_GT) && (b <= CHAR_TLD));
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        hex_digit = (v < 4'd10) ? (CHAR_0 + {4'd0, v}) : (CHAR_A + {4'd0, v} - 8'd10);
    endfunction

endpackage

// File: hdl/quoted_printable_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_printable_encoder
// Quoted-printable encoder: raw message bytes in, encoded characters out.
// ----------------------------------------------------------------------------
// usage
//   input queue: drive data_byte and message_end, raise push; the item is
//   taken on a clock edge with push high and full low.
//   output queue: while empty is low, out_byte, run_last and message_done
//   show the oldest character; pop high takes it.
//   path: with both queues idle, a taken item passes the command queue and
//   the back end's current command before its first character shows.
//   throughput: one output character per cycle while the receiver pops, set
//   by the output register; a literal byte gives 1 character, an escaped byte
//   3, a hard break 2, and a soft break adds 3; a CR waits for the next item
//   and gives nothing until then. The front end handles one token per cycle
//   while the command queue has room, so an item that flushes a held CR as an
//   escape and encodes its own byte makes two tokens, full high for the second.
//   a four-entry command queue sits between front and back end.
//   a stalled receiver fills the output register, then the command queue,
//   then full rises; nothing is lost.
//   reset clears the held CR, the column and all queues; the first item after
//   reset starts a new message at column zero.
// ----------------------------------------------------------------------------
module quoted_printable_encoder
    import qtpe_pkg::*;
#(
    parameter int LINE_MAX = 76
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       message_end,
    input  logic       push,
    output logic       full,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       message_done,
    output logic       empty,
    input  logic       pop
);

    cmd_t wr_cmd;
    cmd_t rd_cmd;
    logic cmd_push;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;

    qtpe_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .message_end (message_end),
        .push        (push),
        .full        (full),
        .cmd         (wr_cmd),
        .cmd_push    (cmd_push),
        .cmd_full    (cmd_full)
    );

    qtpe_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_cmd     (wr_cmd),
        .wr_en      (cmd_push),
        .fifo_full  (cmd_full),
        .rd_cmd     (rd_cmd),
        .rd_en      (cmd_pop),
        .fifo_empty (cmd_empty)
    );

    qtpe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_cmd       (rd_cmd),
        .fifo_empty   (cmd_empty),
        .rd_en        (cmd_pop),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .message_done (message_done),
        .empty        (empty),
        .pop          (pop)
    );

endmodule

// File: hdl/qtpe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtpe_front
// Takes input items, tracks pending CR and line column, and turns each item
// into up to two encoding commands for the back end.
// ----------------------------------------------------------------------------
module qtpe_front
    import qtpe_pkg::*;
#(
    parameter int LINE_MAX = 76
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       message_end,
    input  logic       push,
    output logic       full,
    output cmd_t       cmd,
    output logic       cmd_push,
    input  logic       cmd_full
);

    localparam logic [7:0] LimitCol = 8'(LINE_MAX - 1);

    logic       pending_reg, pending_next;
    logic [6:0] column_reg, column_next;
    logic       sec_valid_reg, sec_valid_next;
    logic [7:0] sec_byte_reg, sec_byte_next;
    logic       sec_end_reg, sec_end_next;
    logic [3:0] sec_cnt_reg, sec_cnt_next;

    logic       accept;
    logic       tok_present;
    logic       tok_crlf;
    logic [7:0] tok_byte;
    logic       tok_last;
    logic       tok_end;
    logic [3:0] cnt_in;
    logic       second;
    logic       esc;
    logic [2:0] tl;
    logic       brk;
    logic [3:0] n_chars;
    logic [3:0] room;
    logic [3:0] len;
    logic [7:0] col_after;
    logic       do_tok;

    assign full   = sec_valid_reg | cmd_full;
    assign accept = push & ~full;

    // pick the token to process this cycle
    always_comb
    begin
        tok_present = 1'b0;
        tok_crlf    = 1'b0;
        tok_byte    = data_byte;
        tok_last    = 1'b1;
        tok_end     = message_end;
        cnt_in      = 4'd0;
        second      = 1'b0;
        if (sec_valid_reg)
        begin
            tok_present = 1'b1;
            tok_byte    = sec_byte_reg;
            tok_end     = sec_end_reg;
            cnt_in      = sec_cnt_reg;
        end
        else if (pending_reg)
        begin
            tok_present = 1'b1;
            if (data_byte == CHAR_LF)
            begin
                tok_crlf = 1'b1;
            end
            else
            begin
                tok_byte = CHAR_CR;
                second   = (data_byte != CHAR_CR) | message_end;
                tok_last = ~second;
            end
        end
        else if (data_byte == CHAR_CR)
        begin
            // lone CR only turns into output at message end
            tok_present = message_end;
        end
        else
        begin
            tok_present = 1'b1;
        end
    end

    assign do_tok = sec_valid_reg ? ~cmd_full : accept;

    always_comb
    begin
        esc       = ~is_literal(tok_byte);
        tl        = tok_crlf ? 3'd0 : (esc ? 3'd3 : 3'd1);
        brk       = ~tok_crlf && (({1'b0, column_reg} + {5'd0, tl}) > LimitCol);
        n_chars   = (brk ? 4'd3 : 4'd0) + (tok_crlf ? 4'd2 : {1'b0, tl});
        room      = MAX_CHARS - cnt_in;
        len       = (n_chars < room) ? n_chars : room;
        col_after = tok_crlf ? 8'd0
                             : ((brk ? 8'd0 : {1'b0, column_reg}) + {5'd0, tl});
    end

    always_comb
    begin
        cmd.brk  = brk;
        cmd.crlf = tok_crlf;
        cmd.esc  = esc;
        cmd.data = tok_byte;
        cmd.len  = len[2:0];
        cmd.last = tok_last;
        cmd.done = tok_last & tok_end;
    end

    assign cmd_push = do_tok & tok_present;

    always_comb
    begin
        pending_next   = pending_reg;
        column_next    = column_reg;
        sec_valid_next = sec_valid_reg;
        sec_byte_next  = sec_byte_reg;
        sec_end_next   = sec_end_reg;
        sec_cnt_next   = sec_cnt_reg;
        if (do_tok)
        begin
            if (tok_present)
            begin
                column_next = col_after[6:0];
            end
            if (tok_last & tok_end)
            begin
                column_next = 7'd0;
            end
            if (sec_valid_reg)
            begin
                sec_valid_next = 1'b0;
            end
            else
            begin
                pending_next   = ~message_end & (data_byte == CHAR_CR);
                sec_valid_next = second;
                sec_byte_next  = (data_byte == CHAR_CR) ? CHAR_CR : data_byte;
                sec_end_next   = message_end;
                sec_cnt_next   = len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            column_reg    <= 7'd0;
            sec_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            column_reg    <= column_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sec_byte_reg <= sec_byte_next;
        sec_end_reg  <= sec_end_next;
        sec_cnt_reg  <= sec_cnt_next;
    end

endmodule

// File: hdl/qtpe_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtpe_cmd_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module qtpe_cmd_fifo
    import qtpe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t wr_cmd,
    input  logic wr_en,
    output logic fifo_full,
    output cmd_t rd_cmd,
    input  logic rd_en,
    output logic fifo_empty
);

    cmd_t                 mem_reg [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_PTR_W:0]   count_reg, count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign fifo_full  = (count_reg == (CMD_PTR_W + 1)'(CMD_FIFO_DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign do_wr      = wr_en & ~fifo_full;
    assign do_rd      = rd_en & ~fifo_empty;
    assign rd_cmd     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{CMD_PTR_W{1'b0}}, do_wr} - {{CMD_PTR_W{1'b0}}, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// File: hdl/qtpe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtpe_back
// Expands commands into output characters, one per cycle while the
// receiver pops, through an output register.
// ----------------------------------------------------------------------------
module qtpe_back
    import qtpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       rd_cmd,
    input  logic       fifo_empty,
    output logic       rd_en,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       message_done,
    output logic       empty,
    input  logic       pop
);

    logic       cur_valid_reg, cur_valid_next;
    cmd_t       cur_reg, cur_next;
    logic [2:0] idx_reg, idx_next;
    logic       ov_reg, ov_next;
    logic [7:0] ob_reg;
    logic       orl_reg;
    logic       omd_reg;

    logic       adv;
    logic       ch_last;
    logic [2:0] j;
    logic [7:0] ch;

    assign adv     = cur_valid_reg & (~ov_reg | pop);
    assign ch_last = (idx_reg == cur_reg.len - 3'd1);
    assign rd_en   = ~fifo_empty & (~cur_valid_reg | (adv & ch_last));

    // character at position idx of the expanded command
    always_comb
    begin
        j  = cur_reg.brk ? idx_reg - 3'd3 : idx_reg;
        ch = cur_reg.data;
        if (cur_reg.brk && (idx_reg < 3'd3))
        begin
            case (idx_reg)
                3'd0:    ch = CHAR_EQ;
                3'd1:    ch = CHAR_CR;
                default: ch = CHAR_LF;
            endcase
        end
        else if (cur_reg.crlf)
        begin
            ch = (j == 3'd0) ? CHAR_CR : CHAR_LF;
        end
        else if (cur_reg.esc)
        begin
            case (j)
                3'd0:    ch = CHAR_EQ;
                3'd1:    ch = hex_digit(cur_reg.data[7:4]);
                default: ch = hex_digit(cur_reg.data[3:0]);
            endcase
        end
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        ov_next        = ov_reg & ~pop;
        if (adv)
        begin
            ov_next  = 1'b1;
            idx_next = idx_reg + 3'd1;
            if (ch_last)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (rd_en)
        begin
            cur_valid_next = 1'b1;
            cur_next       = rd_cmd;
            idx_next       = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        idx_reg <= idx_next;
        if (adv)
        begin
            ob_reg  <= ch;
            orl_reg <= cur_reg.last & ch_last;
            omd_reg <= cur_reg.done & ch_last;
        end
    end

    assign out_byte     = ob_reg;
    assign run_last     = orl_reg;
    assign message_done = omd_reg;
    assign empty        = ~ov_reg;

endmodule

// File: test/tb_quoted_printable_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quoted_printable_encoder
// Self-checking bench: raw message bytes go in through the push/full queue.
// Every encoded character coming out is compared against a software encoder
// that runs alongside. Covers directed corner bytes, then random messages
// under changing idle patterns, with a receiver stall that backs the block up.
// ----------------------------------------------------------------------------
module tb_quoted_printable_encoder
    import qtpe_pkg::*;
();

    localparam int LINE_LEN    = 76;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        logic [7:0] ch;
        logic       run_last;
        logic       message_done;
    } enc_char_t;

    class enc_text_board;
        bit        cr_held;
        int        line_col;
        int        errors;
        enc_char_t item_chars[$];
        enc_char_t expected_chars[$];

        function new();
            cr_held  = 1'b0;
            line_col = 0;
            errors   = 0;
        endfunction

        function bit passes_plain(logic [7:0] b);
            return (b == CHAR_TAB) || (b >= CHAR_SP && b <= CHAR_TLD && b != CHAR_EQ);
        endfunction

        function logic [7:0] hex_ch(logic [3:0] v);
            if (v < 4'd10)
                return CHAR_0 + 8'(v);
            return CHAR_A + 8'(v) - 8'd10;
        endfunction

        function void emit(logic [7:0] ch);
            item_chars.insert(item_chars.size(), '{ch, 1'b0, 1'b0});
        endfunction

        // soft break goes in before a token that would overrun the line
        function void make_room(int len);
            if (line_col + len > LINE_LEN - 1)
            begin
                emit(CHAR_EQ);
                emit(CHAR_CR);
                emit(CHAR_LF);
                line_col = 0;
            end
        endfunction

        function void put_token(logic [7:0] b);
            if (passes_plain(b))
            begin
                make_room(1);
                emit(b);
                line_col += 1;
            end
            else
            begin
                make_room(3);
                emit(CHAR_EQ);
                emit(hex_ch(b[7:4]));
                emit(hex_ch(b[3:0]));
                line_col += 3;
            end
            line_col &= 127;
        endfunction

        // predicts the characters caused by one accepted item
        function void take_byte(logic [7:0] b, logic last);
            item_chars = {};
            if (cr_held)
            begin
                if (b == CHAR_LF)
                begin
                    emit(CHAR_CR);
                    emit(CHAR_LF);
                    line_col = 0;
                    cr_held  = 1'b0;
                end
                else
                begin
                    put_token(CHAR_CR);
                    if (b == CHAR_CR)
                        cr_held = 1'b1;
                    else
                    begin
                        put_token(b);
                        cr_held = 1'b0;
                    end
                end
            end
            else if (b == CHAR_CR)
                cr_held = 1'b1;
            else
                put_token(b);

            if (last)
            begin
                if (cr_held)
                    put_token(CHAR_CR);
                cr_held  = 1'b0;
                line_col = 0;
            end

            if (item_chars.size() > 0)
            begin
                item_chars[item_chars.size() - 1].run_last     = 1'b1;
                item_chars[item_chars.size() - 1].message_done = last;
            end
            foreach (item_chars[i])
                expected_chars.insert(expected_chars.size(), item_chars[i]);
        endfunction

        function void check_char(logic [7:0] ob, logic rl, logic md);
            enc_char_t want;
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected character out_byte=%02h run_last=%b message_done=%b",
                         $time, ob, rl, md);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            if (ob !== want.ch)
            begin
                $display("%0t: out_byte expected %02h actual %02h", $time, want.ch, ob);
                errors++;
            end
            if (rl !== want.run_last)
            begin
                $display("%0t: run_last expected %b actual %b", $time, want.run_last, rl);
                errors++;
            end
            if (md !== want.message_done)
            begin
                $display("%0t: message_done expected %b actual %b",
                         $time, want.message_done, md);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic [7:0] data_byte;
    logic       message_end;
    logic       push;
    logic       full;
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_done;
    logic       empty;
    logic       pop;

    enc_text_board board;
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold;
    int bytes_sent;
    int quiet_cycles;

    quoted_printable_encoder #(
        .LINE_MAX(LINE_LEN)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .message_end (message_end),
        .push        (push),
        .full        (full),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .message_done(message_done),
        .empty       (empty),
        .pop         (pop)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // offers one item and returns at the edge that takes it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        data_byte   <= b;
        message_end <= last;
        do
            @(posedge clk);
        while (full);
        board.take_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_message(input int len);
        logic [7:0] msg[$];
        int r;
        while (msg.size() < len)
        begin
            r = $urandom_range(99);
            if (r < 50)
                msg.insert(msg.size(), 8'($urandom_range(126, 32)));
            else if (r < 62)
            begin
                msg.insert(msg.size(), CHAR_CR);
                if ($urandom_range(99) < 60)
                    msg.insert(msg.size(), CHAR_LF);
            end
            else if (r < 68)
                msg.insert(msg.size(), CHAR_LF);
            else if (r < 72)
                msg.insert(msg.size(), CHAR_TAB);
            else if (r < 76)
                msg.insert(msg.size(), CHAR_EQ);
            else
                msg.insert(msg.size(), 8'($urandom_range(255)));
        end
        foreach (msg[i])
            send_byte(msg[i], i == msg.size() - 1);
    endtask

    task automatic send_random_messages(input int count);
        int start;
        int len;
        start = bytes_sent;
        // long messages are needed to reach the soft break
        while (bytes_sent - start < count)
        begin
            len = ($urandom_range(2) == 0) ? $urandom_range(150, 60)
                                           : $urandom_range(25, 1);
            if (len > count - (bytes_sent - start))
                len = count - (bytes_sent - start);
            send_message(len);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (board.expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random pops, plus a long hold-off on request
    initial
    begin
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                board.check_char(out_byte, run_last, message_done);
            if (recv_hold > 0)
            begin
                recv_hold--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        board         = new();
        send_idle_pct = 11;
        recv_idle_pct = 71;
        recv_hold     = 0;
        bytes_sent    = 0;
        quiet_cycles  = 0;
        rst_n         <= 1'b0;
        push          <= 1'b0;
        data_byte     <= 8'h00;
        message_end   <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // literal range edges, the escaped neighbours and bare LF
        send_byte(CHAR_TAB, 1'b0);
        send_byte(CHAR_SP, 1'b0);
        send_byte(CHAR_LT, 1'b0);
        send_byte(CHAR_EQ, 1'b0);
        send_byte(CHAR_GT, 1'b0);
        send_byte(CHAR_TLD, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        // hard break, CR before another byte, CR before CR
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_A, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        // held CR at message end, alone and after another CR
        send_byte(CHAR_CR, 1'b1);
        send_byte(CHAR_A, 1'b1);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_CR, 1'b1);

        send_random_messages(95);

        send_idle_pct = 71;
        recv_idle_pct = 11;
        send_random_messages(95);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // receiver stalls while the sender keeps offering, so full must rise
        recv_hold = 300;
        send_message(40);
        wait_drained();
        send_random_messages(95);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (board.errors == 0 && board.expected_chars.size() == 0)
            $display("== PASS ==");
        else
        begin
            if (board.expected_chars.size() != 0)
                $display("%0t: %0d expected characters never arrived",
                         $time, board.expected_chars.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/qtpe_pkg.sv
hdl/qtpe_front.sv
hdl/qtpe_cmd_fifo.sv
hdl/qtpe_back.sv
hdl/quoted_printable_encoder.sv
test/tb_quoted_printable_encoder.sv
